[rtl/circular_deque_palindrome_check_top_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the deque palindrome check block
// Clocked implication checks, reset-qualified, reporting by $error.
// ---------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_PALINDROME_CHECK_TOP_ASSERT_SVH
`define CIRCULAR_DEQUE_PALINDROME_CHECK_TOP_ASSERT_SVH

// same-cycle implication
`define CDPC_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define CDPC_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/cdpc_pkg.sv]
// ---------------------------------------------------------------------------
// cdpc_pkg
// Shared constants, codes and control structs of the deque palindrome check.
// ---------------------------------------------------------------------------
package cdpc_pkg;

  localparam int DepthDefault    = 16;
  localparam int MaxCharsDefault = 8;

  localparam int CapW   = 5;
  localparam int FuncW  = 2;
  localparam int CharsW = 64;
  localparam int LenW   = 4;
  localparam int StatW  = 2;
  localparam int OccW   = 5;

  localparam logic [CapW-1:0] CapReset = 5'd16;

  // operation codes
  localparam logic [FuncW-1:0] FuncPushFront = 2'd0;
  localparam logic [FuncW-1:0] FuncPushRear  = 2'd1;
  localparam logic [FuncW-1:0] FuncPopFront  = 2'd2;
  localparam logic [FuncW-1:0] FuncPopRear   = 2'd3;

  // result status codes
  localparam logic [StatW-1:0] StatusDone  = 2'd0;
  localparam logic [StatW-1:0] StatusFull  = 2'd1;
  localparam logic [StatW-1:0] StatusEmpty = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic capture;     // latch the input beat
    logic pop_start;   // move pointer, issue slot read
    logic finish_op;   // push or rejected op: update, load result
    logic finish_pop;  // read data back: load pop result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_pop;
    logic empty;
  } sts_t;

endpackage

[rtl/cdpc_in_if.sv]
// ---------------------------------------------------------------------------
// cdpc_in_if
// Operation channel: valid/ready plus func, string bytes and length.
// ---------------------------------------------------------------------------
interface cdpc_in_if;
  logic                          valid;
  logic                          ready;
  logic [cdpc_pkg::FuncW-1:0]    func;
  logic [cdpc_pkg::CharsW-1:0]   entry_chars;
  logic [cdpc_pkg::LenW-1:0]     entry_len;

  modport source (output valid, func, entry_chars, entry_len, input ready);
  modport sink   (input valid, func, entry_chars, entry_len, output ready);
endinterface

[rtl/cdpc_out_if.sv]
// ---------------------------------------------------------------------------
// cdpc_out_if
// Result channel: valid/ready plus status, popped entry and occupancy.
// ---------------------------------------------------------------------------
interface cdpc_out_if;
  logic                          valid;
  logic                          ready;
  logic [cdpc_pkg::StatW-1:0]    status;
  logic [cdpc_pkg::CharsW-1:0]   popped_chars;
  logic [cdpc_pkg::LenW-1:0]     popped_len;
  logic                          is_palindrome;
  logic [cdpc_pkg::OccW-1:0]     occupancy;

  modport source (output valid, status, popped_chars, popped_len, is_palindrome, occupancy,
                  input ready);
  modport sink   (input valid, status, popped_chars, popped_len, is_palindrome, occupancy,
                  output ready);
endinterface

[rtl/cdpc_ctrl.sv]
// ---------------------------------------------------------------------------
// cdpc_ctrl
// Operation sequencer and result-valid flag.
// ---------------------------------------------------------------------------
module cdpc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  cdpc_pkg::sts_t    sts_i,
  output cdpc_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StExec = 2'd1;
  localparam logic [1:0] StRead = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = StExec;
        end
      end
      StExec: begin
        if (sts_i.is_pop && !sts_i.empty) begin
          cmd_o.pop_start = 1'b1;
          state_d = StRead;
        end else if (out_free) begin
          cmd_o.finish_op = 1'b1;
          state_d = StIdle;
        end
      end
      StRead: begin
        if (out_free) begin
          cmd_o.finish_pop = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    if (cmd_o.finish_op || cmd_o.finish_pop) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/cdpc_dpath.sv]
// ---------------------------------------------------------------------------
// cdpc_dpath
// Capacity register, pointers, slot memory, palindrome compare, result regs.
// ---------------------------------------------------------------------------
module cdpc_dpath #(
  parameter int DEPTH     = cdpc_pkg::DepthDefault,
  parameter int MAX_CHARS = cdpc_pkg::MaxCharsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cdpc_pkg::CapW-1:0]     cfg_wdata_i,
  input  cdpc_pkg::cmd_t                cmd_i,
  output cdpc_pkg::sts_t                sts_o,
  input  logic [cdpc_pkg::FuncW-1:0]    func_i,
  input  logic [cdpc_pkg::CharsW-1:0]   entry_chars_i,
  input  logic [cdpc_pkg::LenW-1:0]     entry_len_i,
  output logic [cdpc_pkg::StatW-1:0]    status_o,
  output logic [cdpc_pkg::CharsW-1:0]   popped_chars_o,
  output logic [cdpc_pkg::LenW-1:0]     popped_len_o,
  output logic                          is_palindrome_o,
  output logic [cdpc_pkg::OccW-1:0]     occupancy_o
);

  localparam int PtrW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW  = $clog2(DEPTH + 1);
  localparam int SLenW = $clog2(MAX_CHARS + 1);
  localparam int SChW  = 8 * MAX_CHARS;
  localparam int SlotW = SLenW + SChW;

  // ---- helpers ----
  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p,
                                               input logic [CntW-1:0] c);
    if (CntW'(p) + CntW'(1) >= c) return '0;
    return p + PtrW'(1);
  endfunction

  function automatic logic [PtrW-1:0] ptr_dec(input logic [PtrW-1:0] p,
                                               input logic [CntW-1:0] c);
    if (p == '0) return PtrW'(c - CntW'(1));
    return p - PtrW'(1);
  endfunction

  // bytes 0..len-1 compared against their mirror; empty string passes
  function automatic logic reads_same(input logic [63:0] c, input logic [3:0] l);
    logic       ok;
    logic [3:0] j;
    ok = 1'b1;
    for (int i = 0; i < 4; i++) begin
      j = l - 4'd1 - 4'(i);
      if ((4'(i) < (l >> 1)) && (c[8*i +: 8] != c[{j[2:0], 3'b000} +: 8])) ok = 1'b0;
    end
    return ok;
  endfunction

  // ---- state ----
  logic [cdpc_pkg::CapW-1:0]  cap_q;
  logic [PtrW-1:0]            head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]            count_q, count_d;
  logic [CntW-1:0]            cap_eff;

  logic [cdpc_pkg::FuncW-1:0] func_q;
  logic [SChW-1:0]            chars_q;
  logic [SLenW-1:0]           len_q;

  logic [SlotW-1:0]           mem [DEPTH];
  logic [SlotW-1:0]           rd_q;

  logic                       full, empty, is_push, do_push;
  logic [PtrW-1:0]            wr_idx, rd_idx;
  logic [cdpc_pkg::LenW-1:0]  len_sat;
  logic [SChW-1:0]            chars_msk;
  logic [63:0]                pop_chars;
  logic [3:0]                 pop_len;

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CntW'(1);
    end else if (32'(cap_q) > 32'(DEPTH)) begin
      cap_eff = CntW'(DEPTH);
    end else begin
      cap_eff = CntW'(cap_q);
    end
  end

  assign full    = (count_q == cap_eff);
  assign empty   = (count_q == '0);
  assign is_push = (func_q == cdpc_pkg::FuncPushFront) || (func_q == cdpc_pkg::FuncPushRear);
  assign do_push = cmd_i.finish_op && is_push && !full;

  assign sts_o.is_pop = !is_push;
  assign sts_o.empty  = empty;

  // input capture: saturate length, clear bytes past it
  always_comb begin
    len_sat = (entry_len_i > 4'(MAX_CHARS)) ? 4'(MAX_CHARS) : entry_len_i;
    for (int b = 0; b < MAX_CHARS; b++) begin
      chars_msk[8*b +: 8] = (4'(b) < len_sat) ? entry_chars_i[8*b +: 8] : 8'h00;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q  <= func_i;
      chars_q <= chars_msk;
      len_q   <= SLenW'(len_sat);
    end
  end

  // pointer and count update
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    wr_idx  = tail_q;
    rd_idx  = head_q;
    if (func_q == cdpc_pkg::FuncPushFront) begin
      wr_idx = ptr_dec(head_q, cap_eff);
    end
    if (func_q == cdpc_pkg::FuncPopRear) begin
      rd_idx = ptr_dec(tail_q, cap_eff);
    end
    if (do_push) begin
      if (func_q == cdpc_pkg::FuncPushFront) begin
        head_d = wr_idx;
      end else begin
        tail_d = ptr_inc(tail_q, cap_eff);
      end
      count_d = count_q + CntW'(1);
    end
    if (cmd_i.pop_start) begin
      if (func_q == cdpc_pkg::FuncPopFront) begin
        head_d = ptr_inc(head_q, cap_eff);
      end else begin
        tail_d = rd_idx;
      end
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= cdpc_pkg::CapReset;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (cfg_we_i) begin
      cap_q   <= cfg_wdata_i;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // slot memory, registered read
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_idx] <= {len_q, chars_q};
    end
    if (cmd_i.pop_start) begin
      rd_q <= mem[rd_idx];
    end
  end

  assign pop_chars = 64'(rd_q[SChW-1:0]);
  assign pop_len   = 4'(rd_q[SlotW-1:SChW]);

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish_op) begin
      status_o        <= !is_push ? cdpc_pkg::StatusEmpty :
                         (full ? cdpc_pkg::StatusFull : cdpc_pkg::StatusDone);
      popped_chars_o  <= '0;
      popped_len_o    <= '0;
      is_palindrome_o <= 1'b0;
      occupancy_o     <= cdpc_pkg::OccW'(count_d);
    end else if (cmd_i.finish_pop) begin
      status_o        <= cdpc_pkg::StatusDone;
      popped_chars_o  <= pop_chars;
      popped_len_o    <= pop_len;
      is_palindrome_o <= reads_same(pop_chars, pop_len);
      occupancy_o     <= cdpc_pkg::OccW'(count_q);
    end
  end

endmodule

[rtl/circular_deque_palindrome_check_top.sv]
// ---------------------------------------------------------------------------
// circular_deque_palindrome_check_top
// Circular deque of short strings with push/pop at both ends and a
// palindrome flag on each popped entry.
// ---------------------------------------------------------------------------
//  channel    dir  handshake     payload
//  item_i     in   valid/ready   func, entry_chars, entry_len
//  result_o   out  valid/ready   status, popped_chars, popped_len,
//                                is_palindrome, occupancy
//  cfg        in   cfg_we_i      cfg_wdata_i (capacity, clears the deque)
//
//  Steps: a push or a rejected op is accepted in idle and finished in the
//  execute step; a successful pop adds a read step for the slot memory's
//  registered read port. The result beat is valid from the edge that ends
//  the op's last step; the next op is accepted back in idle.
//  Reset: pointers and count cleared, capacity 16; slots are not cleared.
//  Stalls: the result register holds until taken; a finished op waits in
//  its last step while the result register is still occupied.
// ---------------------------------------------------------------------------
`include "circular_deque_palindrome_check_top_assert.svh"

module circular_deque_palindrome_check_top #(
  parameter int DEPTH     = cdpc_pkg::DepthDefault,
  parameter int MAX_CHARS = cdpc_pkg::MaxCharsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cdpc_pkg::CapW-1:0]   cfg_wdata_i,
  cdpc_in_if.sink                     item_i,
  cdpc_out_if.source                  result_o
);

  cdpc_pkg::cmd_t cmd;
  cdpc_pkg::sts_t sts;

  // sequencer: one op in flight, result-valid flag
  cdpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // pointers, slot memory, compare and result payload
  cdpc_dpath #(
    .DEPTH     (DEPTH),
    .MAX_CHARS (MAX_CHARS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .func_i          (item_i.func),
    .entry_chars_i   (item_i.entry_chars),
    .entry_len_i     (item_i.entry_len),
    .status_o        (result_o.status),
    .popped_chars_o  (result_o.popped_chars),
    .popped_len_o    (result_o.popped_len),
    .is_palindrome_o (result_o.is_palindrome),
    .occupancy_o     (result_o.occupancy)
  );

  // ---- checks ----
  // one op at a time: no accept right after an accept
  `CDPC_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni,
                    item_i.valid && item_i.ready, !item_i.ready,
                    "second beat accepted while op in flight")
  // empty pop reports nothing popped and an empty deque
  `CDPC_ASSERT_IMPL(a_empty_pop, clk_i, rst_ni,
                    result_o.valid && (result_o.status == cdpc_pkg::StatusEmpty),
                    (result_o.popped_len == '0) && (result_o.occupancy == '0)
                      && !result_o.is_palindrome,
                    "empty status with data")
  // popped data only comes with done status
  `CDPC_ASSERT_IMPL(a_pop_done, clk_i, rst_ni,
                    result_o.valid && (result_o.popped_len != '0),
                    result_o.status == cdpc_pkg::StatusDone,
                    "popped entry without done status")

endmodule

[test/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the circular string deque with palindrome flag.
// A directed table covers the empty and full rejects, length saturation,
// garbage above the length, the empty string and capacity extremes. Random
// fill and drain bursts then sweep a set of capacities. Every result beat is
// matched, field by field, against its table row or the in-bench deque predictor.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SettleCycles = 4;     // idle gap before capacity writes
  localparam int TailCycles   = 8;     // quiet time after the last result
  localparam int QuietLimit   = 2000;  // cycles with no beat on either side
  localparam int SweepItems   = 128;   // random ops per capacity setting

  // one expected result beat
  typedef struct packed {
    logic [cdpc_pkg::StatW-1:0]  status;
    logic [cdpc_pkg::CharsW-1:0] popped_chars;
    logic [cdpc_pkg::LenW-1:0]   popped_len;
    logic                        is_palindrome;
    logic [cdpc_pkg::OccW-1:0]   occupancy;
  } deque_result_t;

  // one row of the directed table: either a capacity write or an op
  typedef struct {
    bit                          cfg_write;
    logic [cdpc_pkg::CapW-1:0]   cap;
    logic [cdpc_pkg::FuncW-1:0]  func;
    logic [cdpc_pkg::CharsW-1:0] chars;
    logic [cdpc_pkg::LenW-1:0]   len;
    bit                          typed;     // result given in the row, not predicted
    deque_result_t               result;
  } step_row_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i;
  logic [cdpc_pkg::CapW-1:0] cfg_wdata_i;

  cdpc_in_if  item_if ();
  cdpc_out_if result_if ();

  circular_deque_palindrome_check_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_if),
    .result_o    (result_if)
  );

  always #6 clk_i = ~clk_i;

  // ---- predictor state: our own copy of the deque ----
  logic [cdpc_pkg::CharsW-1:0] slot_bytes [cdpc_pkg::DepthDefault];
  int                          slot_size  [cdpc_pkg::DepthDefault];
  int                          front, back, fill;
  logic [cdpc_pkg::CapW-1:0]   cap_setting = cdpc_pkg::CapReset;

  deque_result_t awaited_results [$];   // results still owed by the block
  int            mismatches;
  bit            calm;                  // no idling on either side while set

  // run statistics for the closing summary
  int ops_accepted, pushes_stored, pops_done, palindromes, full_rejects;
  int empty_rejects, cap_settings;

  // capacity as the block uses it: 0 acts as 1, above DEPTH acts as DEPTH
  function automatic int usable_slots();
    if (cap_setting == '0) return 1;
    if (int'(cap_setting) > cdpc_pkg::DepthDefault) return cdpc_pkg::DepthDefault;
    return int'(cap_setting);
  endfunction

  function automatic bit reads_both_ways(logic [cdpc_pkg::CharsW-1:0] bytes, int n);
    for (int i = 0; i < n / 2; i++) begin
      if (bytes[8*i +: 8] != bytes[8*(n-1-i) +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Apply one op to the predictor and return the beat the block owes for it.
  function automatic deque_result_t predict_deque_op(
      logic [cdpc_pkg::FuncW-1:0] func, logic [cdpc_pkg::CharsW-1:0] chars,
      logic [cdpc_pkg::LenW-1:0] len_in);
    deque_result_t r;
    int cap, idx, n;
    r   = '0;
    cap = usable_slots();
    n   = (int'(len_in) > cdpc_pkg::MaxCharsDefault) ? cdpc_pkg::MaxCharsDefault
                                                      : int'(len_in);
    if (func == cdpc_pkg::FuncPushFront || func == cdpc_pkg::FuncPushRear) begin
      if (fill >= cap) begin
        r.status = cdpc_pkg::StatusFull;
        full_rejects++;
      end else begin
        if (func == cdpc_pkg::FuncPushFront) begin
          front = (front == 0) ? cap - 1 : front - 1;
          if (front >= cap) front = 0;
          idx = front;
        end else begin
          idx  = (back < cap) ? back : 0;
          back = (idx + 1 >= cap) ? 0 : idx + 1;
        end
        // bytes above the length are dropped on the way in
        slot_bytes[idx] = (n >= 8) ? chars : chars & ((64'd1 << (8 * n)) - 64'd1);
        slot_size[idx]  = n;
        fill++;
        pushes_stored++;
      end
    end else begin
      if (fill == 0) begin
        r.status = cdpc_pkg::StatusEmpty;
        empty_rejects++;
      end else begin
        if (func == cdpc_pkg::FuncPopFront) begin
          idx   = (front < cap) ? front : 0;
          front = (idx + 1 >= cap) ? 0 : idx + 1;
        end else begin
          back = (back == 0) ? cap - 1 : back - 1;
          if (back >= cap) back = 0;
          idx = back;
        end
        r.popped_chars  = slot_bytes[idx];
        r.popped_len    = cdpc_pkg::LenW'(slot_size[idx]);
        r.is_palindrome = reads_both_ways(slot_bytes[idx], slot_size[idx]);
        fill--;
        pops_done++;
        if (r.is_palindrome) palindromes++;
      end
    end
    r.occupancy = cdpc_pkg::OccW'(fill);
    return r;
  endfunction

  // results that can be read straight off the op, for the directed table
  function automatic deque_result_t stored_at(int occ);
    return '{cdpc_pkg::StatusDone, '0, '0, 1'b0, cdpc_pkg::OccW'(occ)};
  endfunction

  function automatic deque_result_t full_at(int occ);
    return '{cdpc_pkg::StatusFull, '0, '0, 1'b0, cdpc_pkg::OccW'(occ)};
  endfunction

  function automatic deque_result_t nothing_to_pop();
    return '{cdpc_pkg::StatusEmpty, '0, '0, 1'b0, '0};
  endfunction

  function automatic void check_field(string name, logic [cdpc_pkg::CharsW-1:0] want,
                                      logic [cdpc_pkg::CharsW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Random push payload: mostly palindromes and near misses, the rest noise.
  // Bytes above the length are always random so their clearing is checked.
  function automatic void random_string(output logic [cdpc_pkg::CharsW-1:0] chars,
                                        output logic [cdpc_pkg::LenW-1:0] len);
    int n, kind;
    logic [7:0] b;
    chars = {$urandom, $urandom};
    if ($urandom_range(99) < 10) begin
      len = cdpc_pkg::LenW'($urandom_range(15, 9));   // saturates to eight
      n   = cdpc_pkg::MaxCharsDefault;
    end else begin
      n   = $urandom_range(cdpc_pkg::MaxCharsDefault);
      len = cdpc_pkg::LenW'(n);
    end
    kind = $urandom_range(99);
    if (kind < 60) begin
      for (int i = 0; i < n / 2; i++) begin
        // small alphabet now and then so some mirrors happen by chance
        b = (kind < 15) ? 8'(8'h61 + $urandom_range(2)) : 8'($urandom);
        chars[8*i +: 8]       = b;
        chars[8*(n-1-i) +: 8] = b;
      end
      if (kind >= 45 && n >= 2) chars[$urandom_range(7)] ^= 1'b1;  // near miss
    end
  endfunction

  // Present one op, hold it until accepted, and log what it must produce.
  task automatic run_op(logic [cdpc_pkg::FuncW-1:0] func,
                        logic [cdpc_pkg::CharsW-1:0] chars,
                        logic [cdpc_pkg::LenW-1:0] len, bit typed,
                        deque_result_t typed_result);
    deque_result_t predicted;
    while (!calm && $urandom_range(99) < 28) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid       <= 1'b1;
    item_if.func        <= func;
    item_if.entry_chars <= chars;
    item_if.entry_len   <= len;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    ops_accepted++;
    predicted = predict_deque_op(func, chars, len);
    awaited_results.push_back(typed ? typed_result : predicted);
  endtask

  // Capacity writes happen only with the block drained; the write also
  // empties the deque.
  task automatic set_capacity(logic [cdpc_pkg::CapW-1:0] value);
    item_if.valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cap_setting = value;
    front = 0;
    back  = 0;
    fill  = 0;
    cap_settings++;
  endtask

  // ---- result side: random backpressure and the scoreboard ----
  always @(posedge clk_i) result_if.ready <= calm || ($urandom_range(99) >= 28);

  always @(posedge clk_i) begin : result_check
    deque_result_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (awaited_results.size() == 0) begin
        $error("result beat with none outstanding: status %0d, occupancy %0d",
               result_if.status, result_if.occupancy);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        check_field("status", want.status, result_if.status);
        check_field("popped_chars", want.popped_chars, result_if.popped_chars);
        check_field("popped_len", want.popped_len, result_if.popped_len);
        check_field("is_palindrome", want.is_palindrome, result_if.is_palindrome);
        check_field("occupancy", want.occupancy, result_if.occupancy);
      end
    end
  end

  // Watchdog: a hang shows up as a long run of cycles with no beat moving.
  int quiet_cycles;
  always @(posedge clk_i) begin
    if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("timeout: no beat for %0d cycles, %0d results outstanding",
               quiet_cycles, awaited_results.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // ---- stimulus ----
  step_row_t directed_steps [24];

  // Random sweep: small, full-size and out-of-range capacities, each written
  // while idle. 0 must act as 1, 17 and 31 as 16.
  logic [cdpc_pkg::CapW-1:0] sweep_caps [10] = '{5'd2, 5'd16, 5'd7, 5'd1, 5'd17,
                                                 5'd16, 5'd4, 5'd0, 5'd31, 5'd11};

  initial begin
    logic [cdpc_pkg::FuncW-1:0]  func;
    logic [cdpc_pkg::CharsW-1:0] chars;
    logic [cdpc_pkg::LenW-1:0]   len;
    bit                          filling, pushing;
    int                          burst_left, roll;

    item_if.valid       <= 1'b0;
    item_if.func        <= cdpc_pkg::FuncPushFront;
    item_if.entry_chars <= '0;
    item_if.entry_len   <= '0;
    cfg_we_i            <= 1'b0;
    cfg_wdata_i         <= cdpc_pkg::CapReset;

    // Directed part. Pushes and rejects carry their result in the row;
    // pops are left to the predictor.
    directed_steps = '{
      // empty after reset: both pops rejected
      '{1'b0, '0, cdpc_pkg::FuncPopFront, 64'h0, 4'd0, 1'b1, nothing_to_pop()},
      '{1'b0, '0, cdpc_pkg::FuncPopRear,  64'h0, 4'd0, 1'b1, nothing_to_pop()},
      // "abba", all ones with a length past eight, empty string over
      // garbage, "racecar" with a stray top byte
      '{1'b0, '0, cdpc_pkg::FuncPushRear,  64'h0000_0000_6162_6261, 4'd4, 1'b1, stored_at(1)},
      '{1'b0, '0, cdpc_pkg::FuncPushFront, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1, stored_at(2)},
      '{1'b0, '0, cdpc_pkg::FuncPushRear,  64'hDEAD_BEEF_CAFE_F00D, 4'd0, 1'b1, stored_at(3)},
      '{1'b0, '0, cdpc_pkg::FuncPushFront, 64'hEE72_6163_6563_6172, 4'd7, 1'b1, stored_at(4)},
      '{1'b0, '0, cdpc_pkg::FuncPopFront, 64'h0, 4'd0, 1'b0, '0},
      '{1'b0, '0, cdpc_pkg::FuncPopFront, 64'h0, 4'd0, 1'b0, '0},
      '{1'b0, '0, cdpc_pkg::FuncPopRear,  64'h0, 4'd0, 1'b0, '0},
      '{1'b0, '0, cdpc_pkg::FuncPopRear,  64'h0, 4'd0, 1'b0, '0},
      '{1'b0, '0, cdpc_pkg::FuncPopRear,  64'h0, 4'd0, 1'b1, nothing_to_pop()},
      // "ab" is not a palindrome
      '{1'b0, '0, cdpc_pkg::FuncPushRear,  64'h0000_0000_0000_6261, 4'd2, 1'b1, stored_at(1)},
      '{1'b0, '0, cdpc_pkg::FuncPopFront, 64'h0, 4'd0, 1'b0, '0},
      '{1'b0, '0, cdpc_pkg::FuncPushFront, 64'h5555_AAAA_5555_AAAA, 4'd9, 1'b1, stored_at(1)},
      '{1'b0, '0, cdpc_pkg::FuncPopRear,  64'h0, 4'd0, 1'b0, '0},
      // capacity 0 acts as one slot: second push of either kind is full
      '{1'b1, 5'd0, cdpc_pkg::FuncPushFront, 64'h0, 4'd0, 1'b0, '0},
      '{1'b0, '0, cdpc_pkg::FuncPushFront, 64'h0000_0000_0000_007A, 4'd1, 1'b1, stored_at(1)},
      '{1'b0, '0, cdpc_pkg::FuncPushRear,  64'h1234_5678_9ABC_DEF0, 4'd8, 1'b1, full_at(1)},
      '{1'b0, '0, cdpc_pkg::FuncPushFront, 64'h0000_0000_0000_0001, 4'd1, 1'b1, full_at(1)},
      '{1'b0, '0, cdpc_pkg::FuncPopRear,  64'h0, 4'd0, 1'b0, '0},
      '{1'b0, '0, cdpc_pkg::FuncPopFront, 64'h0, 4'd0, 1'b1, nothing_to_pop()},
      // capacity 31 acts as sixteen
      '{1'b1, 5'd31, cdpc_pkg::FuncPushFront, 64'h0, 4'd0, 1'b0, '0},
      '{1'b0, '0, cdpc_pkg::FuncPushRear,  64'h0102_0304_0403_0201, 4'd8, 1'b1, stored_at(1)},
      '{1'b0, '0, cdpc_pkg::FuncPopFront, 64'h0, 4'd0, 1'b0, '0}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].cfg_write) begin
        set_capacity(directed_steps[i].cap);
      end else begin
        run_op(directed_steps[i].func, directed_steps[i].chars, directed_steps[i].len,
               directed_steps[i].typed, directed_steps[i].result);
      end
    end

    // Random part. Alternating fill and drain bursts, sized to the capacity,
    // push the deque into both the full and the empty corner over and over;
    // a tenth of the ops are picked blindly.
    foreach (sweep_caps[p]) begin
      set_capacity(sweep_caps[p]);
      calm       = (p == 5);   // one full-rate stretch, no idling either side
      filling    = 1'b0;
      burst_left = 0;
      for (int k = 0; k < SweepItems; k++) begin
        if (burst_left == 0) begin
          filling    = !filling;
          burst_left = $urandom_range(3 * usable_slots() + 2, 1);
        end
        burst_left--;
        roll = $urandom_range(99);
        if (roll < 10) begin
          func = cdpc_pkg::FuncW'($urandom_range(3));
        end else begin
          pushing = filling ? (roll < 82) : (roll >= 82);
          if (pushing) begin
            func = $urandom_range(1) ? cdpc_pkg::FuncPushRear : cdpc_pkg::FuncPushFront;
          end else begin
            func = $urandom_range(1) ? cdpc_pkg::FuncPopRear : cdpc_pkg::FuncPopFront;
          end
        end
        random_string(chars, len);
        run_op(func, chars, len, 1'b0, '0);
      end
    end
    calm = 1'b0;

    // drain, then give a stray extra beat time to show up
    item_if.valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("covered %0d ops over %0d capacity settings: %0d stored, %0d popped",
             ops_accepted, cap_settings, pushes_stored, pops_done);
    $display("  %0d popped palindromes, %0d full rejects, %0d empty rejects",
             palindromes, full_rejects, empty_rejects);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/cdpc_pkg.sv
rtl/cdpc_in_if.sv
rtl/cdpc_out_if.sv
rtl/cdpc_ctrl.sv
rtl/cdpc_dpath.sv
rtl/circular_deque_palindrome_check_top.sv
test/tb_top.sv
